// ===== sv/ffa_pkg.sv =====
// Shared constants and types for the first-fit free-list allocator.
// No dependencies; the channel interfaces, the allocator unit and the bench refer to it by scoped name.
package ffa_pkg;

   localparam int POOL_UNITS_DEF = 1024;
   localparam int UNIT_BYTES_DEF = 8;

   localparam int REQ_BYTES_W    = 14;
   localparam int FREE_ADDR_W    = 13;
   localparam int PAYLOAD_ADDR_W = 13;
   localparam int BLOCK_BYTES_W  = 14;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_AREAD,
      ST_AWAIT,
      ST_AW_REPL,
      ST_AW_CUR,
      ST_AW_PREV,
      ST_FHRD,
      ST_FHDAT,
      ST_FRD,
      ST_FRDAT,
      ST_FAFT,
      ST_FAFT_DAT,
      ST_FW_HDR,
      ST_FW_PREV,
      ST_FIN
   } state_type;

endpackage

// ===== sv/ffa_req_if.sv =====
// Request channel of the allocator: valid/ready plus command payload.
// Depends on ffa_pkg for field widths.
interface ffa_req_if;
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic [ffa_pkg::REQ_BYTES_W-1:0]   req_bytes;
   logic [ffa_pkg::FREE_ADDR_W-1:0]   free_addr;

   modport source (output valid, cmd, req_bytes, free_addr, input ready);
   modport sink   (input valid, cmd, req_bytes, free_addr, output ready);
endinterface

// ===== sv/ffa_rsp_if.sv =====
// Response channel of the allocator: valid/ready plus result payload.
// Depends on ffa_pkg for field widths.
interface ffa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ok;
   logic [ffa_pkg::PAYLOAD_ADDR_W-1:0]  payload_addr;
   logic [ffa_pkg::BLOCK_BYTES_W-1:0]   block_bytes;

   modport source (output valid, ok, payload_addr, block_bytes, input ready);
   modport sink   (input valid, ok, payload_addr, block_bytes, output ready);
endinterface

// ===== sv/ffa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/ffa_div.sv =====
// Pipelined divide of an unsigned value by a constant: reciprocal multiply,
// back-multiply and one correction step. No dependencies.
module ffa_div #(
   parameter int DW      = 14,
   parameter int DIVISOR = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_value,
   output logic          out_valid,
   output logic [DW-1:0] quot,
   output logic [DW-1:0] rem
);

   localparam int SH = DW + $clog2(DIVISOR) + 1;
   localparam int PW = DW + SH + 1;
   localparam int MW = DW + $clog2(DIVISOR + 1);
   localparam logic [SH:0] RECIP = (SH+1)'((64'd1 << SH) / DIVISOR + 64'd1);

   logic          v1_ff, v2_ff, v3_ff;
   logic [PW-1:0] prod_ff;
   logic [DW-1:0] val1_ff, val2_ff, q2_ff;
   logic [DW-1:0] quot_ff, rem_ff;
   logic [MW-1:0] back_w;
   logic [DW-1:0] rem_raw_w;
   logic [DW-1:0] quot_in, rem_in;

   always_comb begin
      back_w    = MW'(q2_ff) * MW'(DIVISOR);
      rem_raw_w = val2_ff - DW'(back_w);
      quot_in   = q2_ff;
      rem_in    = rem_raw_w;
      // estimate can fall one short; fix it up
      if (rem_raw_w >= DW'(DIVISOR)) begin
         quot_in = q2_ff + DW'(1);
         rem_in  = rem_raw_w - DW'(DIVISOR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      prod_ff <= PW'(in_value) * PW'(RECIP);
      val1_ff <= in_value;
      q2_ff   <= prod_ff[SH +: DW];
      val2_ff <= val1_ff;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign out_valid = v3_ff;
   assign quot      = quot_ff;
   assign rem       = rem_ff;

endmodule

// ===== sv/first_fit_free_list_allocator_unit.sv =====
// First-fit free-list allocator over a pool of POOL_UNITS units of UNIT_BYTES.
// Channels: req_ch (sink) takes one command per beat: cmd selects allocate
// (req_bytes) or free (free_addr). rsp_ch (source) returns exactly one beat per
// command: ok, payload_addr, block_bytes. Both use valid/ready.
// Each segment header (size, next link, live mark) sits in one synchronous
// RAM; commands are handled one at a time by a sequencer.
// An allocate walks the list with one RAM read per hole visited, then writes
// the split remainder, the taken segment and, if needed, the previous hole's
// link; a free reads its header, walks the list to find its neighbor, reads
// an adjacent next hole to merge it, then writes its header and updates the
// previous hole, if any. The walk through the RAM (one read per hole) sets the rate.
// After reset the block runs a clearing pass over the RAM, one write per unit,
// with req_ch.ready low; then the whole pool is one free hole.
// A finished result waits in an output register; the next command is taken
// while it waits, and its own result holds until rsp_ch.ready frees the slot.
module first_fit_free_list_allocator_unit #(
   parameter int POOL_UNITS = ffa_pkg::POOL_UNITS_DEF,
   parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ffa_req_if.sink      req_ch,
   ffa_rsp_if.source    rsp_ch
);

   localparam int LW = $clog2(POOL_UNITS + 1);
   localparam int IW = $clog2(POOL_UNITS);
   localparam int EW = 2 * LW + 1;
   localparam int DW = ffa_pkg::REQ_BYTES_W;
   localparam int CW = (LW > DW) ? LW : DW;
   localparam int AW = ffa_pkg::PAYLOAD_ADDR_W;
   localparam int BW = ffa_pkg::BLOCK_BYTES_W;
   localparam int FW = ffa_pkg::FREE_ADDR_W;
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_UNITS);
   localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_UNITS - 1);

   ffa_pkg::state_type state_ff, state_in;

   logic [IW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic          prev_valid_ff, prev_valid_in;
   logic [EW-1:0] prev_ent_ff, prev_ent_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic          cmd_ff, cmd_in;
   logic [FW-1:0] addr_ff, addr_in;
   logic [CW-1:0] need_ff, need_in;
   logic [IW-1:0] hdr_ff, hdr_in;
   logic [LW-1:0] cur_size_ff, cur_size_in;
   logic [LW-1:0] cur_link_ff, cur_link_in;
   logic [LW-1:0] repl_ff, repl_in;
   logic [LW-1:0] nfin_ff, nfin_in;
   logic [LW-1:0] total_ff, total_in;
   logic [LW-1:0] nxt_ff, nxt_in;
   logic          res_ok_ff, res_ok_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [BW-1:0] res_bytes_ff, res_bytes_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [BW-1:0] rsp_bytes_ff, rsp_bytes_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   logic          div_in_valid, div_out_valid;
   logic [DW-1:0] div_in_value, div_quot, div_rem;

   logic          accept_w;
   logic [LW-1:0] rd_size, rd_link, prev_size, prev_link, after_w;
   logic          rd_live, prev_live;
   logic [31:0]   hdr_full_w, alloc_addr_w, alloc_bytes_w, free_bytes_w;

   ffa_ram #(.WIDTH(EW), .DEPTH(POOL_UNITS)) u_seg_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ffa_div #(.DW(DW), .DIVISOR(UNIT_BYTES)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_in_valid),
      .in_value  (div_in_value),
      .out_valid (div_out_valid),
      .quot      (div_quot),
      .rem       (div_rem)
   );

   assign req_ch.ready        = (state_ff == ffa_pkg::ST_IDLE);
   assign accept_w            = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.payload_addr = rsp_addr_ff;
   assign rsp_ch.block_bytes  = rsp_bytes_ff;

   assign rd_size   = ram_rdata[LW-1:0];
   assign rd_link   = ram_rdata[2*LW-1:LW];
   assign rd_live   = ram_rdata[2*LW];
   assign prev_size = prev_ent_ff[LW-1:0];
   assign prev_link = prev_ent_ff[2*LW-1:LW];
   assign prev_live = prev_ent_ff[2*LW];

   assign div_in_valid = accept_w &&
                         !(req_ch.cmd == ffa_pkg::CMD_ALLOC && req_ch.req_bytes == '0);
   assign div_in_value = (req_ch.cmd == ffa_pkg::CMD_FREE) ? DW'(req_ch.free_addr)
                                                           : req_ch.req_bytes;

   assign hdr_full_w    = 32'(div_quot) - 32'd1;
   assign alloc_addr_w  = (32'(cursor_ff) + 32'd1) * 32'(UNIT_BYTES);
   assign alloc_bytes_w = 32'(nfin_ff) * 32'(UNIT_BYTES);
   assign free_bytes_w  = 32'(cur_size_ff) * 32'(UNIT_BYTES);
   assign after_w       = prev_valid_ff ? prev_link : head_ff;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      head_in       = head_ff;
      cursor_in     = cursor_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      prev_ent_in   = prev_ent_ff;
      steps_in      = steps_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      hdr_in        = hdr_ff;
      cur_size_in   = cur_size_ff;
      cur_link_in   = cur_link_ff;
      repl_in       = repl_ff;
      nfin_in       = nfin_ff;
      total_in      = total_ff;
      nxt_in        = nxt_ff;
      res_ok_in     = res_ok_ff;
      res_addr_in   = res_addr_ff;
      res_bytes_in  = res_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      case (state_ff)
         ffa_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            // unit zero starts as the single hole spanning the pool
            ram_wdata = (clr_cnt_ff == '0) ? {1'b0, NULL_LINK, NULL_LINK} : '0;
            clr_cnt_in = clr_cnt_ff + IW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         ffa_pkg::ST_IDLE: begin
            if (accept_w) begin
               cmd_in  = req_ch.cmd;
               addr_in = req_ch.free_addr;
               if (div_in_valid) begin
                  state_in = ffa_pkg::ST_DIV;
               end else begin
                  res_ok_in    = 1'b0;
                  res_addr_in  = '0;
                  res_bytes_in = '0;
                  state_in     = ffa_pkg::ST_FIN;
               end
            end
         end
         ffa_pkg::ST_DIV: begin
            if (div_out_valid) begin
               if (cmd_ff == ffa_pkg::CMD_ALLOC) begin
                  need_in       = CW'(div_quot) + CW'(div_rem != '0) + CW'(1);
                  cursor_in     = head_ff;
                  prev_valid_in = 1'b0;
                  steps_in      = '0;
                  state_in      = ffa_pkg::ST_AREAD;
               end else if (div_rem != '0 || div_quot == '0 ||
                            hdr_full_w >= 32'(POOL_UNITS)) begin
                  res_ok_in    = 1'b0;
                  res_addr_in  = '0;
                  res_bytes_in = '0;
                  state_in     = ffa_pkg::ST_FIN;
               end else begin
                  hdr_in   = IW'(hdr_full_w);
                  state_in = ffa_pkg::ST_FHRD;
               end
            end
         end
         ffa_pkg::ST_AREAD: begin
            if (cursor_ff >= NULL_LINK) begin
               res_ok_in    = 1'b0;
               res_addr_in  = '0;
               res_bytes_in = '0;
               state_in     = ffa_pkg::ST_FIN;
            end else begin
               ram_raddr = cursor_ff[IW-1:0];
               state_in  = ffa_pkg::ST_AWAIT;
            end
         end
         ffa_pkg::ST_AWAIT: begin
            if (CW'(rd_size) >= need_ff) begin
               cur_size_in = rd_size;
               cur_link_in = rd_link;
               if (CW'(rd_size) > need_ff &&
                   (CW+1)'(cursor_ff) + (CW+1)'(need_ff) < (CW+1)'(NULL_LINK)) begin
                  repl_in  = LW'(CW'(cursor_ff) + need_ff);
                  nfin_in  = need_ff[LW-1:0];
                  state_in = ffa_pkg::ST_AW_REPL;
               end else begin
                  // exact fit: unlink the hole
                  repl_in  = rd_link;
                  nfin_in  = rd_size;
                  state_in = ffa_pkg::ST_AW_CUR;
               end
            end else if (steps_ff == NULL_LINK) begin
               res_ok_in    = 1'b0;
               res_addr_in  = '0;
               res_bytes_in = '0;
               state_in     = ffa_pkg::ST_FIN;
            end else begin
               prev_in       = cursor_ff;
               prev_ent_in   = ram_rdata;
               prev_valid_in = 1'b1;
               cursor_in     = rd_link;
               steps_in      = steps_ff + LW'(1);
               state_in      = ffa_pkg::ST_AREAD;
            end
         end
         ffa_pkg::ST_AW_REPL: begin
            ram_we    = 1'b1;
            ram_waddr = repl_ff[IW-1:0];
            ram_wdata = {1'b0, cur_link_ff, cur_size_ff - need_ff[LW-1:0]};
            state_in  = ffa_pkg::ST_AW_CUR;
         end
         ffa_pkg::ST_AW_CUR: begin
            ram_we       = 1'b1;
            ram_waddr    = cursor_ff[IW-1:0];
            ram_wdata    = {1'b1, cur_link_ff, nfin_ff};
            res_ok_in    = 1'b1;
            res_addr_in  = alloc_addr_w[AW-1:0];
            res_bytes_in = alloc_bytes_w[BW-1:0];
            if (prev_valid_ff) begin
               state_in = ffa_pkg::ST_AW_PREV;
            end else begin
               head_in  = repl_ff;
               state_in = ffa_pkg::ST_FIN;
            end
         end
         ffa_pkg::ST_AW_PREV: begin
            ram_we    = 1'b1;
            ram_waddr = prev_ff[IW-1:0];
            ram_wdata = {prev_live, repl_ff, prev_size};
            state_in  = ffa_pkg::ST_FIN;
         end
         ffa_pkg::ST_FHRD: begin
            ram_raddr = hdr_ff;
            state_in  = ffa_pkg::ST_FHDAT;
         end
         ffa_pkg::ST_FHDAT: begin
            if (!rd_live) begin
               res_ok_in    = 1'b0;
               res_addr_in  = '0;
               res_bytes_in = '0;
               state_in     = ffa_pkg::ST_FIN;
            end else begin
               cur_size_in = rd_size;
               if (head_ff < NULL_LINK && LW'(hdr_ff) >= head_ff) begin
                  cursor_in = head_ff;
                  steps_in  = '0;
                  state_in  = ffa_pkg::ST_FRD;
               end else begin
                  prev_valid_in = 1'b0;
                  state_in      = ffa_pkg::ST_FAFT;
               end
            end
         end
         ffa_pkg::ST_FRD: begin
            ram_raddr = cursor_ff[IW-1:0];
            state_in  = ffa_pkg::ST_FRDAT;
         end
         ffa_pkg::ST_FRDAT: begin
            if (steps_ff == NULL_LINK || rd_link >= NULL_LINK || LW'(hdr_ff) < rd_link) begin
               prev_in       = cursor_ff;
               prev_ent_in   = ram_rdata;
               prev_valid_in = 1'b1;
               state_in      = ffa_pkg::ST_FAFT;
            end else begin
               cursor_in = rd_link;
               steps_in  = steps_ff + LW'(1);
               state_in  = ffa_pkg::ST_FRD;
            end
         end
         ffa_pkg::ST_FAFT: begin
            if (after_w < NULL_LINK &&
                (LW+1)'(hdr_ff) + (LW+1)'(cur_size_ff) == (LW+1)'(after_w)) begin
               ram_raddr = after_w[IW-1:0];
               state_in  = ffa_pkg::ST_FAFT_DAT;
            end else begin
               total_in = cur_size_ff;
               nxt_in   = after_w;
               state_in = ffa_pkg::ST_FW_HDR;
            end
         end
         ffa_pkg::ST_FAFT_DAT: begin
            // absorb the adjacent following hole
            total_in = cur_size_ff + rd_size;
            nxt_in   = rd_link;
            state_in = ffa_pkg::ST_FW_HDR;
         end
         ffa_pkg::ST_FW_HDR: begin
            ram_we       = 1'b1;
            ram_waddr    = hdr_ff;
            ram_wdata    = {1'b0, nxt_ff, total_ff};
            res_ok_in    = 1'b1;
            res_addr_in  = addr_ff;
            res_bytes_in = free_bytes_w[BW-1:0];
            if (prev_valid_ff) begin
               state_in = ffa_pkg::ST_FW_PREV;
            end else begin
               head_in  = LW'(hdr_ff);
               state_in = ffa_pkg::ST_FIN;
            end
         end
         ffa_pkg::ST_FW_PREV: begin
            ram_we    = 1'b1;
            ram_waddr = prev_ff[IW-1:0];
            if ((LW+1)'(prev_ff) + (LW+1)'(prev_size) == (LW+1)'(hdr_ff)) begin
               ram_wdata = {prev_live, nxt_ff, prev_size + total_ff};
            end else begin
               ram_wdata = {prev_live, LW'(hdr_ff), prev_size};
            end
            state_in = ffa_pkg::ST_FIN;
         end
         ffa_pkg::ST_FIN: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_addr_in  = res_addr_ff;
               rsp_bytes_in = res_bytes_ff;
               state_in     = ffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffa_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         head_ff       <= '0;
         cursor_ff     <= NULL_LINK;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         head_ff       <= head_in;
         cursor_ff     <= cursor_in;
         prev_valid_ff <= prev_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prev_ff      <= prev_in;
      prev_ent_ff  <= prev_ent_in;
      steps_ff     <= steps_in;
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      need_ff      <= need_in;
      hdr_ff       <= hdr_in;
      cur_size_ff  <= cur_size_in;
      cur_link_ff  <= cur_link_in;
      repl_ff      <= repl_in;
      nfin_ff      <= nfin_in;
      total_ff     <= total_in;
      nxt_ff       <= nxt_in;
      res_ok_ff    <= res_ok_in;
      res_addr_ff  <= res_addr_in;
      res_bytes_ff <= res_bytes_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept_w |=> !req_ch.ready)
      else $error("request taken while a command is in progress");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_addr_ff == '0 && rsp_bytes_ff == '0)
      else $error("refused beat carries nonzero address or size");

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_out_valid |-> state_ff == ffa_pkg::ST_DIV)
      else $error("divider result outside the divide wait state");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NULL_LINK)
      else $error("list head beyond the null link");

endmodule

// ===== bench/alloc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the first-fit allocator: watches both channels, keeps a shadow
// free list and compares every result beat. Depends on ffa_pkg.
module alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [13:0] req_bytes,
   input  logic [12:0] req_free_addr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_ok,
   input  logic [12:0] rsp_payload_addr,
   input  logic [13:0] rsp_block_bytes,
   output int          fail_count,
   output int          pending
);
   localparam int PU = ffa_pkg::POOL_UNITS_DEF;
   localparam int UB = ffa_pkg::UNIT_BYTES_DEF;
   localparam int NUL = PU;

   typedef struct packed {
      logic        ok;
      logic [12:0] addr;
      logic [13:0] bytes;
   } grant_type;

   int        hole_size [PU];
   int        hole_link [PU];
   bit        live [PU];
   int        head;
   grant_type expected_grants [$];

   function automatic grant_type predict_alloc(int req);
      grant_type g;
      int need, prev, cur, steps, repl;
      g = '0;
      prev = NUL;
      steps = 0;
      if (req == 0) return g;
      need = (req + UB - 1) / UB + 1;
      cur = head;
      while (cur < NUL && steps < PU && hole_size[cur] < need) begin
         prev = cur;
         cur = hole_link[cur];
         steps++;
      end
      if (cur >= NUL || hole_size[cur] < need) return g;
      if (hole_size[cur] > need && cur + need < NUL) begin
         repl = cur + need;
         hole_size[repl] = hole_size[cur] - need;
         hole_link[repl] = hole_link[cur];
      end else begin
         repl = hole_link[cur];
         need = hole_size[cur];
      end
      if (prev < NUL) hole_link[prev] = repl;
      else head = repl;
      hole_size[cur] = need;
      live[cur] = 1;
      g.ok = 1;
      g.addr = 13'((cur + 1) * UB);
      g.bytes = 14'(need * UB);
      return g;
   endfunction

   function automatic grant_type predict_free(int addr);
      grant_type g;
      int hdr, sz, total, nxt, prev, steps, after;
      g = '0;
      steps = 0;
      if (addr % UB != 0 || addr < UB) return g;
      hdr = addr / UB - 1;
      if (hdr >= NUL || !live[hdr]) return g;
      sz = hole_size[hdr];
      live[hdr] = 0;
      prev = NUL;
      if (head < NUL && hdr >= head) begin
         prev = head;
         while (steps < PU) begin
            nxt = (prev < NUL) ? hole_link[prev] : NUL;
            if (nxt >= NUL || hdr < nxt) break;
            prev = nxt;
            steps++;
         end
      end
      after = (prev < NUL) ? hole_link[prev] : head;
      total = sz;
      nxt = after;
      if (after < NUL && hdr + sz == after) begin
         total += hole_size[after];
         nxt = hole_link[after];
      end
      hole_size[hdr] = total;
      hole_link[hdr] = nxt;
      if (prev >= NUL) head = hdr;
      else if (prev + hole_size[prev] == hdr) begin
         hole_size[prev] += total;
         hole_link[prev] = nxt;
      end else hole_link[prev] = hdr;
      g.ok = 1;
      g.addr = 13'(addr);
      g.bytes = 14'(sz * UB);
      return g;
   endfunction

   assign pending = expected_grants.size();

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         fail_count <= 0;
         head = 0;
         hole_size[0] = PU;
         hole_link[0] = NUL;
         foreach (live[i]) live[i] = 0;
         expected_grants.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_cmd == ffa_pkg::CMD_ALLOC)
               expected_grants.push_back(predict_alloc(req_bytes));
            else
               expected_grants.push_back(predict_free(req_free_addr));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected result beat ok=%0d addr=%0d bytes=%0d", $time,
                        rsp_ok, rsp_payload_addr, rsp_block_bytes);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_grants.pop_front();
               if (want != {rsp_ok, rsp_payload_addr, rsp_block_bytes}) begin
                  $display("%0t: mismatch expected ok=%0d addr=%0d bytes=%0d, got ok=%0d addr=%0d bytes=%0d",
                           $time, want.ok, want.addr, want.bytes,
                           rsp_ok, rsp_payload_addr, rsp_block_bytes);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the allocator bench: clock, reset, command stimulus and verdict.
// Depends on ffa_pkg, the channel interfaces, the block and alloc_checker.
module tb_top;
   localparam int CYCLE_LIMIT = 10000000;

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   int   fail_count;
   int   pending;
   logic [12:0] granted [$];

   ffa_req_if req_ch();
   ffa_rsp_if rsp_ch();

   first_fit_free_list_allocator_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   alloc_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_cmd(req_ch.cmd),
      .req_bytes(req_ch.req_bytes), .req_free_addr(req_ch.free_addr),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_ok(rsp_ch.ok),
      .rsp_payload_addr(rsp_ch.payload_addr), .rsp_block_bytes(rsp_ch.block_bytes),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = ffa_pkg::CMD_ALLOC;
      req_ch.req_bytes = 0;
      req_ch.free_addr = 0;
   end

   // track granted payload offsets so frees mostly hit live blocks
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.ok &&
          rsp_ch.block_bytes != 0 && !(rsp_ch.payload_addr inside {granted}))
         granted.push_back(rsp_ch.payload_addr);

   // random stall on the result side
   initial begin
      int gap;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // valid stays up after a beat until the next gap or drain drops it
   task automatic send_beat(logic c, int nbytes, int addr);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= c;
      req_ch.req_bytes <= 14'(nbytes);
      req_ch.free_addr <= 13'(addr);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic alloc_beat(int nbytes);
      send_beat(ffa_pkg::CMD_ALLOC, nbytes, $urandom_range(0, 8191));
   endtask

   task automatic free_beat(int addr);
      send_beat(ffa_pkg::CMD_FREE, $urandom_range(0, 16383), addr);
   endtask

   task automatic free_live();
      int k;
      drain();
      if (granted.size() == 0) begin
         free_beat($urandom_range(0, 8191));
      end else begin
         k = $urandom_range(0, granted.size() - 1);
         free_beat(granted[k]);
         granted.delete(k);
      end
   endtask

   initial begin
      int pick;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: zero request, oversized, exact fit, bad frees
      alloc_beat(0);
      alloc_beat(16383);
      alloc_beat(8192);
      alloc_beat(1);
      alloc_beat(8);
      alloc_beat(9);
      alloc_beat(100);
      free_beat(3);
      free_beat(0);
      free_beat(8184);
      free_beat(8191);
      drain();
      free_beat(16);      // not a block start: refused
      free_beat(16);      // same address again: refused
      free_beat(8);       // frees the first block
      free_beat(56);      // not a block start: refused
      free_beat(32);
      drain();
      granted.delete();
      alloc_beat(8184);   // larger than any hole: refused
      alloc_beat(1);
      free_beat(8);
      alloc_beat(8176);
      alloc_beat(1);
      free_beat(16);
      free_beat(8);
      drain();
      granted.delete();
      for (int i = 0; i < 1700; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            alloc_beat(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                   : $urandom_range(1, 300));
         else if (pick < 90)
            free_live();
         else
            free_beat($urandom_range(0, 8191));
         if (i == 800) drain();
      end
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/ffa_pkg.sv
sv/ffa_req_if.sv
sv/ffa_rsp_if.sv
sv/ffa_ram.sv
sv/ffa_div.sv
sv/first_fit_free_list_allocator_unit.sv
bench/alloc_checker.sv
bench/tb_top.sv
